// ===== rtl/msp_pkg.sv =====
// Shared types, constants and the log2 table of the smooth-coloring pixel engine.
`timescale 1ns / 1ps

package msp_pkg;

   // Fixed-point layout
   localparam int FRAC_BITS    = 28;
   localparam int DIM_BITS     = 12;
   localparam int MAX_ITER_DEF = 256;
   localparam int C_W          = 32;             // point coordinate, signed Q4.28
   localparam int Z_W          = 34;             // iterate, signed
   localparam int MAG_W        = 32;             // iterate magnitude fed to multipliers
   localparam int SQ_W         = 2 * MAG_W - FRAC_BITS;
   localparam int NORM_W       = SQ_W + 1;       // |z|^2
   localparam int LOG_Y_W      = 23;             // log2 result, Q16
   localparam int CSR_W        = 32;
   localparam int CSR_IDX_W    = 3;

   // Smooth count terms, Q16: one + LN2 term + the 16.0 offset of the second log
   localparam int LN2_TERM     = 100189;
   localparam int SMOOTH_BIAS  = 65536 + LN2_TERM + 16 * 65536;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_REAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_IMAG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd4;

   typedef struct packed {
      logic [DIM_BITS-1:0] pixel_x;
      logic [DIM_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic       inside_set;
      logic [8:0] steps_taken;
   } rsp_type;

   // log2(1 + i/16) in Q16, i = 0..16
   function automatic logic [16:0] log2_tab(input logic [4:0] idx);
      logic [16:0] val;
      unique case (idx)
         5'd0:    val = 17'd0;
         5'd1:    val = 17'd5732;
         5'd2:    val = 17'd11136;
         5'd3:    val = 17'd16248;
         5'd4:    val = 17'd21098;
         5'd5:    val = 17'd25711;
         5'd6:    val = 17'd30109;
         5'd7:    val = 17'd34312;
         5'd8:    val = 17'd38336;
         5'd9:    val = 17'd42196;
         5'd10:   val = 17'd45904;
         5'd11:   val = 17'd49472;
         5'd12:   val = 17'd52911;
         5'd13:   val = 17'd56229;
         5'd14:   val = 17'd59434;
         5'd15:   val = 17'd62534;
         5'd16:   val = 17'd65536;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/msp_norm_cell.sv =====
// One normalizer cell: shift left by a fixed amount when the top bits are clear.
`timescale 1ns / 1ps

module msp_norm_cell import msp_pkg::*; #(
   parameter int W     = NORM_W,
   parameter int CW    = 6,
   parameter int SHIFT = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [W-1:0]  in_data,
   input  logic [CW-1:0] in_cnt,
   output logic          out_valid,
   output logic [W-1:0]  out_data,
   output logic [CW-1:0] out_cnt
);

   logic          valid_ff;
   logic [W-1:0]  data_ff, data_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // shift out a block of leading zeros and count it
   always_comb begin
      if (in_data[W-1 -: SHIFT] == '0) begin
         data_in = in_data << SHIFT;
         cnt_in  = in_cnt + CW'(SHIFT);
      end else begin
         data_in = in_data;
         cnt_in  = in_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_cnt   = cnt_ff;

endmodule

// ===== rtl/msp_log2_unit.sv =====
// Fixed-point log2 in Q16: row of normalizer cells, then table lookup with interpolation.
`timescale 1ns / 1ps

module msp_log2_unit import msp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [NORM_W-1:0]  in_x,
   output logic               out_valid,
   output logic [LOG_Y_W-1:0] out_y
);

   localparam int NCELL = $clog2(NORM_W);
   localparam int CNT_W = NCELL;

   logic [NORM_W-1:0] data_w  [NCELL+1];
   logic [CNT_W-1:0]  cnt_w   [NCELL+1];
   logic              valid_w [NCELL+1];

   assign data_w[0]  = in_x;
   assign cnt_w[0]   = '0;
   assign valid_w[0] = in_valid;

   // chain of cells, largest shift first
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      msp_norm_cell #(
         .W     (NORM_W),
         .CW    (CNT_W),
         .SHIFT (1 << (NCELL - 1 - i))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_data   (data_w[i]),
         .in_cnt    (cnt_w[i]),
         .out_valid (valid_w[i+1]),
         .out_data  (data_w[i+1]),
         .out_cnt   (cnt_w[i+1])
      );
   end

   logic [CNT_W-1:0]   lead_pos;
   logic [4:0]         idx;
   logic [11:0]        frac;
   logic [16:0]        base;
   logic [16:0]        upper;
   logic [16:0]        diff;
   logic [28:0]        step_prod;
   logic [LOG_Y_W-1:0] y_in, y_ff;
   logic               valid_ff;

   // integer part from the leading one, fraction from table and linear step
   always_comb begin
      lead_pos  = CNT_W'(NORM_W - 1) - cnt_w[NCELL];
      idx       = {1'b0, data_w[NCELL][NORM_W-2 -: 4]};
      frac      = data_w[NCELL][NORM_W-6 -: 12];
      base      = log2_tab(idx);
      upper     = log2_tab(idx + 5'd1);
      diff      = upper - base;
      step_prod = 29'(diff) * 29'(frac);
      y_in      = LOG_Y_W'({lead_pos, 16'b0}) + LOG_Y_W'(base)
                + LOG_Y_W'(step_prod[28:12]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_w[NCELL];
      end
      y_ff <= y_in;
   end

   assign out_valid = valid_ff;
   assign out_y     = y_ff;

endmodule

// ===== rtl/msp_iter_core.sv =====
// Escape-time iterator: one z = z*z + c step per cycle with the escape test.
`timescale 1ns / 1ps

module msp_iter_core import msp_pkg::*; #(
   parameter int MAX_ITER = MAX_ITER_DEF,
   parameter int ITER_W   = $clog2(MAX_ITER + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic signed [C_W-1:0] c_real,
   input  logic signed [C_W-1:0] c_imag,
   output logic                  done,
   output logic                  escaped,
   output logic [ITER_W-1:0]     count,
   output logic [NORM_W-1:0]     norm
);

   localparam int WW = SQ_W + 2;
   localparam logic [NORM_W-1:0] FOUR = NORM_W'(4) << FRAC_BITS;

   logic signed [Z_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [C_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic [ITER_W-1:0]     k_ff, k_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  esc_ff, esc_in;
   logic [ITER_W-1:0]     count_ff, count_in;
   logic [NORM_W-1:0]     norm_ff, norm_in;

   logic [Z_W-1:0]         abs_r, abs_i;
   logic [MAG_W-1:0]       mag_r, mag_i;
   logic [2*MAG_W-1:0]     prod_rr, prod_ii, prod_ri;
   logic [SQ_W-1:0]        rr, ii, ri;
   logic signed [WW-1:0]   ri_s, zr_wide, zi_wide;
   logic [NORM_W-1:0]      norm_sum;

   // squares and cross product of the current iterate
   always_comb begin
      abs_r    = zr_ff[Z_W-1] ? -zr_ff : zr_ff;
      abs_i    = zi_ff[Z_W-1] ? -zi_ff : zi_ff;
      mag_r    = abs_r[MAG_W-1:0];
      mag_i    = abs_i[MAG_W-1:0];
      prod_rr  = mag_r * mag_r;
      prod_ii  = mag_i * mag_i;
      prod_ri  = mag_r * mag_i;
      rr       = prod_rr[2*MAG_W-1:FRAC_BITS];
      ii       = prod_ii[2*MAG_W-1:FRAC_BITS];
      ri       = prod_ri[2*MAG_W-1:FRAC_BITS];
      ri_s     = (zr_ff[Z_W-1] ^ zi_ff[Z_W-1]) ? -$signed({2'b0, ri}) : $signed({2'b0, ri});
      zr_wide  = $signed({2'b0, rr}) - $signed({2'b0, ii})
               + $signed({{(WW-C_W){cr_ff[C_W-1]}}, cr_ff});
      zi_wide  = (ri_s <<< 1) + $signed({{(WW-C_W){ci_ff[C_W-1]}}, ci_ff});
      norm_sum = {1'b0, rr} + {1'b0, ii};
   end

   // escape on the norm of the iterate held, or stop at MAX_ITER; otherwise advance
   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      k_in     = k_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      esc_in   = esc_ff;
      count_in = count_ff;
      norm_in  = norm_ff;
      if (load) begin
         zr_in  = '0;
         zi_in  = '0;
         cr_in  = c_real;
         ci_in  = c_imag;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (norm_sum > FOUR) begin
            run_in   = 1'b0;
            done_in  = 1'b1;
            esc_in   = 1'b1;
            count_in = k_ff - ITER_W'(1);
            norm_in  = norm_sum;
         end else if (k_ff == ITER_W'(MAX_ITER)) begin
            run_in   = 1'b0;
            done_in  = 1'b1;
            esc_in   = 1'b0;
            count_in = k_ff;
         end else begin
            zr_in = zr_wide[Z_W-1:0];
            zi_in = zi_wide[Z_W-1:0];
            k_in  = k_ff + ITER_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      k_ff     <= k_in;
      esc_ff   <= esc_in;
      count_ff <= count_in;
      norm_ff  <= norm_in;
   end

   assign done    = done_ff;
   assign escaped = esc_ff;
   assign count   = count_ff;
   assign norm    = norm_ff;

endmodule

// ===== rtl/mandelbrot_smooth_pixel_top.sv =====
// Escape-time pixel engine with smooth gray-level coloring.
//
// Usage: raise start with a pixel on req_data; the transfer happens at the edge where
// start is high and busy is low. busy stays high while the pixel is worked on.
// The result appears on rsp_data for exactly one cycle with rsp_valid high; the
// receiver cannot hold it off. One pixel is processed at a time.
// Sequence: coordinate mapping (offset products, then centering and saturation), the
// iterator, then for an escaped pixel two passes through the log2 unit and, unless the
// smooth count is out of range, gray-level scaling; the result is registered after that.
// The iteration loop dominates the time from the accepting edge to the result.
// Registers are written through csr_we / csr_index / csr_wdata, by the user only while
// busy is low (the block does not enforce this); indexes past the list are ignored.
// Reset (synchronous, active high) returns to idle, drops any pixel in flight and
// loads the default view.
`timescale 1ns / 1ps

module mandelbrot_smooth_pixel_top import msp_pkg::*; #(
   parameter int MAX_ITER = MAX_ITER_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam int SIZE_W = DIM_BITS + 1;
   localparam int DIFF_W = DIM_BITS + 2;
   localparam int MAP_W  = DIFF_W + 32;
   localparam int DIV_W  = NORM_W;

   // gray level = floor((smooth*255 >> 16) / MAX_ITER) by reciprocal multiplication
   localparam int LOG_MI = $clog2(MAX_ITER);
   localparam int MQ_W   = 8 + LOG_MI;
   localparam int SHR    = MQ_W + LOG_MI;
   localparam int RCP_W  = MQ_W + 2;
   localparam int PRD_W  = MQ_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << SHR) + 64'(MAX_ITER) - 64'd1) / 64'(MAX_ITER));

   localparam logic signed [MAP_W-1:0] C_MAX = (MAP_W'(1) <<< (C_W - 1)) - MAP_W'(1);
   localparam logic signed [MAP_W-1:0] C_MIN = ~C_MAX;
   localparam logic signed [31:0]      SMOOTH_LIM = 32'(MAX_ITER) << 16;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAP  = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_ITER = 3'd3;
   localparam logic [2:0] S_LOGA = 3'd4;
   localparam logic [2:0] S_LOGB = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;

   // configuration registers
   logic signed [C_W-1:0] center_real_ff, center_imag_ff;
   logic [30:0]           pixel_step_ff;
   logic [SIZE_W-1:0]     image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_real_ff  <= -32'sd134217728;
         center_imag_ff  <= '0;
         pixel_step_ff   <= 31'd786432;
         image_width_ff  <= SIZE_W'(1024);
         image_height_ff <= SIZE_W'(768);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_REAL:  center_real_ff  <= csr_wdata;
            CSR_CENTER_IMAG:  center_imag_ff  <= csr_wdata;
            CSR_PIXEL_STEP:   pixel_step_ff   <= csr_wdata[30:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [2:0]              state_ff, state_in;
   logic [DIM_BITS-1:0]     px_ff, px_in, py_ff, py_in;
   logic signed [MAP_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [MAP_W-1:0] cx_wide, cy_wide;
   logic signed [C_W-1:0]   c_real, c_imag;
   logic                    core_load;
   logic                    core_done, core_esc;
   logic [ITER_W-1:0]       core_count;
   logic [NORM_W-1:0]       core_norm;
   logic                    log_in_valid, log_out_valid;
   logic [NORM_W-1:0]       log_x;
   logic [LOG_Y_W-1:0]      log_y, l1;
   logic signed [31:0]      smooth;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [PRD_W-1:0]        scaled;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // pixel offset products
   always_comb begin
      dx    = $signed({1'b0, px_ff, 1'b0}) - $signed({1'b0, image_width_ff});
      dy    = $signed({1'b0, py_ff, 1'b0}) - $signed({1'b0, image_height_ff});
      tx_in = dx * $signed({1'b0, pixel_step_ff});
      ty_in = dy * $signed({1'b0, pixel_step_ff});
   end

   // halve toward minus infinity, add center, saturate
   always_comb begin
      cx_wide = $signed({{(MAP_W-C_W){center_real_ff[C_W-1]}}, center_real_ff}) + (tx_ff >>> 1);
      cy_wide = $signed({{(MAP_W-C_W){center_imag_ff[C_W-1]}}, center_imag_ff}) + (ty_ff >>> 1);
      if (cx_wide > C_MAX) begin
         c_real = C_MAX[C_W-1:0];
      end else if (cx_wide < C_MIN) begin
         c_real = C_MIN[C_W-1:0];
      end else begin
         c_real = cx_wide[C_W-1:0];
      end
      if (cy_wide > C_MAX) begin
         c_imag = C_MAX[C_W-1:0];
      end else if (cy_wide < C_MIN) begin
         c_imag = C_MIN[C_W-1:0];
      end else begin
         c_imag = cy_wide[C_W-1:0];
      end
   end

   msp_iter_core #(
      .MAX_ITER (MAX_ITER),
      .ITER_W   (ITER_W)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .load    (core_load),
      .c_real  (c_real),
      .c_imag  (c_imag),
      .done    (core_done),
      .escaped (core_esc),
      .count   (core_count),
      .norm    (core_norm)
   );

   msp_log2_unit u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (log_in_valid),
      .in_x      (log_x),
      .out_valid (log_out_valid),
      .out_y     (log_y)
   );

   // first log feeds the norm, second log its result less the fraction offset
   always_comb begin
      l1           = log_y - LOG_Y_W'(FRAC_BITS * 65536);
      log_x        = (state_ff == S_ITER) ? core_norm : NORM_W'(l1);
      log_in_valid = ((state_ff == S_ITER) && core_done && core_esc)
                   || ((state_ff == S_LOGA) && log_out_valid);
      core_load    = (state_ff == S_SUM);
      smooth       = $signed(32'(core_count) << 16) + 32'(SMOOTH_BIAS)
                   - $signed(32'(log_y));
      scaled       = PRD_W'(rem_ff[16 +: MQ_W]) * PRD_W'(RECIP);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               px_in    = req_data.pixel_x;
               py_in    = req_data.pixel_y;
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_ITER;
         end
         S_ITER: begin
            if (core_done) begin
               if (core_esc) begin
                  state_in = S_LOGA;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.brightness  = 8'd0;
                  rsp_in.inside_set  = 1'b1;
                  rsp_in.steps_taken = 9'(core_count);
                  state_in           = S_IDLE;
               end
            end
         end
         S_LOGA: begin
            if (log_out_valid) begin
               state_in = S_LOGB;
            end
         end
         S_LOGB: begin
            if (log_out_valid) begin
               rsp_in.inside_set  = 1'b0;
               rsp_in.steps_taken = 9'(core_count);
               if (smooth[31] || (smooth >= SMOOTH_LIM)) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.brightness = 8'd0;
                  state_in          = S_IDLE;
               end else begin
                  rem_in   = (DIV_W'(smooth[30:0]) << 8) - DIV_W'(smooth[30:0]);
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rsp_valid_in      = 1'b1;
            rsp_in.brightness = scaled[SHR +: 8];
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff  <= px_in;
      py_ff  <= py_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the smooth-coloring pixel engine: table, then random views.
`timescale 1ns / 1ps

module tb_top;
   import msp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd5;
   localparam int RANDOM_PIXELS = 1900;
   localparam int DRAIN_CYCLES  = 40;

   typedef enum int {VIEW_DEFAULT, VIEW_POINT, VIEW_WIDE, VIEW_EDGE, VIEW_ZERO} view_type;

   typedef struct {
      view_type view;
      int       px;
      int       py;
      bit       typed;
      rsp_type  want;
   } pixel_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // view registers as the engine should hold them
   longint   view_cr, view_ci;
   longint   view_step, view_w, view_h;
   rsp_type  pending_pixels[$];
   int       error_count = 0;
   int       inside_count = 0, escaped_count = 0, view_count = 0;

   const longint lg_tab[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
      38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

   mandelbrot_smooth_pixel_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fixed-point product, magnitude truncated, saturated to 2^62 - 1
   function automatic longint fx_mul(longint a, longint b);
      logic          neg;
      logic [127:0]  ua, ub, prod;
      logic [63:0]   r;
      neg  = (a < 0) != (b < 0);
      ua   = {64'd0, (a < 0) ? -a : a};
      ub   = {64'd0, (b < 0) ? -b : b};
      prod = ua * ub;
      r    = prod[63 + FRAC_BITS:FRAC_BITS];
      if (r > 64'h3FFF_FFFF_FFFF_FFFF) r = 64'h3FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // log2 in Q16: leading one, four index bits, twelve interpolation bits
   function automatic longint log2_q16(logic [63:0] x);
      int          p;
      logic [63:0] y;
      int          idx;
      longint      f, base;
      if (x == 0) return 0;
      p = 63;
      while (!x[p]) p--;
      y    = x << (63 - p);
      idx  = y[62:59];
      f    = y[58:47];
      base = lg_tab[idx];
      return longint'(p) * 65536 + base + ((lg_tab[idx + 1] - base) * f) / 4096;
   endfunction

   // pixel to plane coordinate, offset floored, saturated to [-8, 8)
   function automatic longint plane_coord(int pix, longint size, longint center);
      longint t, c;
      t = (longint'(pix) * 2 - size) * view_step;
      c = center + (t >>> 1);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      return c;
   endfunction

   function automatic rsp_type shade_pixel(req_type pix);
      longint  cr, ci, zr, zi, rr, ii, ri, norm, l1, l2, smooth;
      int      n;
      rsp_type res;
      cr   = plane_coord(pix.pixel_x, view_w, view_cr);
      ci   = plane_coord(pix.pixel_y, view_h, view_ci);
      zr   = 0;
      zi   = 0;
      norm = 0;
      res  = '0;
      for (n = 0; n < MAX_ITER_DEF; n++) begin
         rr   = fx_mul(zr, zr);
         ii   = fx_mul(zi, zi);
         ri   = fx_mul(zr, zi);
         zr   = rr - ii + cr;
         zi   = ri * 2 + ci;
         norm = fx_mul(zr, zr) + fx_mul(zi, zi);
         if (norm > (longint'(4) << FRAC_BITS)) break;
      end
      res.steps_taken = n[8:0];
      if (n == MAX_ITER_DEF) begin
         res.inside_set = 1'b1;
      end else begin
         l1     = log2_q16(norm) - longint'(FRAC_BITS) * 65536;
         l2     = log2_q16(l1) - 16 * 65536;
         smooth = longint'(n) * 65536 + 65536 + LN2_TERM - l2;
         if (smooth >= longint'(MAX_ITER_DEF) * 65536 || smooth < 0) begin
            res.brightness = 8'd0;
         end else begin
            l1 = (smooth * 255 / MAX_ITER_DEF) / 65536;
            if (l1 > 255) l1 = 255;
            res.brightness = l1[7:0];
         end
      end
      return res;
   endfunction

   // one register write per cycle; caller lowers the enable
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CENTER_REAL:  view_cr = longint'($signed(val));
         CSR_CENTER_IMAG:  view_ci = longint'($signed(val));
         CSR_PIXEL_STEP:   view_step = val[30:0];
         CSR_IMAGE_WIDTH:  view_w = val[12:0];
         CSR_IMAGE_HEIGHT: view_h = val[12:0];
         default: ;
      endcase
   endtask

   task automatic load_view(logic [31:0] cr, logic [31:0] ci, logic [31:0] step,
                            logic [31:0] w, logic [31:0] h);
      csr_write(CSR_CENTER_REAL, cr);
      csr_write(CSR_CENTER_IMAG, ci);
      csr_write(CSR_PIXEL_STEP, step);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_we <= 1'b0;
      view_count++;
   endtask

   // hold start and data until the engine takes the pixel, then queue its result
   task automatic send_pixel(req_type pix, bit typed, rsp_type want);
      rsp_type res;
      start    <= 1'b1;
      req_data <= pix;
      do @(posedge clock); while (busy);
      res = typed ? want : shade_pixel(pix);
      if (res.inside_set) inside_count++; else escaped_count++;
      pending_pixels.push_back(res);
   endtask

   // wait for every queued result, then let the engine settle
   task automatic drain();
      start <= 1'b0;
      while (pending_pixels.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // check each result transfer against the oldest queued one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.brightness !== want.brightness) begin
               $error("brightness expected %0d actual %0d", want.brightness,
                      rsp_data.brightness);
               error_count++;
            end
            if (rsp_data.inside_set !== want.inside_set) begin
               $error("inside_set expected %0d actual %0d", want.inside_set,
                      rsp_data.inside_set);
               error_count++;
            end
            if (rsp_data.steps_taken !== want.steps_taken) begin
               $error("steps_taken expected %0d actual %0d", want.steps_taken,
                      rsp_data.steps_taken);
               error_count++;
            end
         end
      end
   end

   initial begin
      pixel_row_type rows[$];
      pixel_row_type row;
      view_type   cur_view;
      req_type    pix;
      rsp_type    none, inside_px, saturated;
      int         sent, phase_len, burst_left, w, h, shift, i;
      logic [31:0] cr, ci, step;

      none      = '0;
      inside_px = '{brightness: 8'd0, inside_set: 1'b1, steps_taken: 9'd256};
      saturated = '{brightness: 8'd0, inside_set: 1'b0, steps_taken: 9'd0};
      rows = '{
         '{VIEW_DEFAULT, 512, 384, 1, inside_px},
         '{VIEW_DEFAULT, 0, 0, 0, none},
         '{VIEW_DEFAULT, 4095, 4095, 0, none},
         '{VIEW_DEFAULT, 1023, 767, 0, none},
         '{VIEW_DEFAULT, 0, 384, 0, none},
         '{VIEW_DEFAULT, 700, 384, 0, none},
         '{VIEW_DEFAULT, 300, 200, 0, none},
         '{VIEW_DEFAULT, 2730, 1365, 0, none},
         '{VIEW_POINT, 0, 0, 1, inside_px},
         '{VIEW_POINT, 4095, 0, 1, inside_px},
         '{VIEW_WIDE, 0, 0, 1, saturated},
         '{VIEW_WIDE, 4095, 4095, 1, saturated},
         '{VIEW_WIDE, 4095, 0, 1, saturated},
         '{VIEW_EDGE, 2048, 2048, 0, none},
         '{VIEW_EDGE, 0, 4095, 0, none},
         '{VIEW_ZERO, 0, 0, 1, inside_px},
         '{VIEW_ZERO, 100, 50, 0, none},
         '{VIEW_ZERO, 4095, 4095, 0, none}
      };

      view_cr = -134217728; view_ci = 0; view_step = 786432; view_w = 1024; view_h = 768;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; reset view first, then one register set per view
      cur_view = VIEW_DEFAULT;
      foreach (rows[k]) begin
         row = rows[k];
         if (row.view != cur_view) begin
            drain();
            case (row.view)
               VIEW_POINT: load_view(32'd0, 32'd0, 32'd0, 32'd1024, 32'd1024);
               VIEW_WIDE:  load_view(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'd1);
               VIEW_EDGE: begin
                  csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
                  load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd8191, 32'd8191);
               end
               default:    load_view(32'hF800_0000, 32'd0, 32'd1 << 20, 32'd0, 32'd0);
            endcase
            cur_view = row.view;
         end
         pix.pixel_x = row.px[11:0];
         pix.pixel_y = row.py[11:0];
         send_pixel(pix, row.typed, row.want);
      end

      // random views, each drained before its registers change
      sent = 0;
      burst_left = 0;
      while (sent < RANDOM_PIXELS) begin
         drain();
         if ($urandom_range(0, 9) == 0) begin
            cr = $urandom; ci = $urandom; step = $urandom;
            w = $urandom_range(0, 8191); h = $urandom_range(0, 8191);
         end else begin
            w  = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 64);
            h  = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 64);
            cr = $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
            ci = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            shift = $urandom_range(0, 14);
            step = ((32'd3 << FRAC_BITS) / w) >> shift;
            if ($urandom_range(0, 15) == 0) step = 0;
         end
         load_view(cr, ci, step, w, h);
         phase_len = $urandom_range(40, 160);
         for (i = 0; i < phase_len && sent < RANDOM_PIXELS; i++) begin
            // bursts of back-to-back transfers, mostly with idle gaps between
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               start <= 1'b0;
               repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20))
                  @(posedge clock);
            end
            burst_left--;
            if ($urandom_range(0, 9) == 0) begin
               pix.pixel_x = DIM_BITS'($urandom);
               pix.pixel_y = DIM_BITS'($urandom);
            end else begin
               pix.pixel_x = DIM_BITS'($urandom_range(0,
                                (w > 0 && w <= 4096) ? w - 1 : 4095));
               pix.pixel_y = DIM_BITS'($urandom_range(0,
                                (h > 0 && h <= 4096) ? h - 1 : 4095));
            end
            send_pixel(pix, 1'b0, none);
            sent++;
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d register views, %0d pixels inside the set, %0d escaped",
               view_count, inside_count, escaped_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hard stop on a hung engine
   initial begin
      #30ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/msp_pkg.sv
rtl/msp_norm_cell.sv
rtl/msp_log2_unit.sv
rtl/msp_iter_core.sv
rtl/mandelbrot_smooth_pixel_top.sv
bench/tb_top.sv
